### rtl/fifo_queue_with_key_removal_macros.svh
// assertion macros for the queue with key removal
`ifndef FIFO_QUEUE_WITH_KEY_REMOVAL_MACROS_SVH
`define FIFO_QUEUE_WITH_KEY_REMOVAL_MACROS_SVH

// same-cycle implication, disabled in reset
`define FQKR_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("fqkr assertion failed");

// next-cycle implication, disabled in reset
`define FQKR_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("fqkr assertion failed");

`endif

### rtl/fqkr_pkg.sv
// shared types and codes for the queue with key removal
package fqkr_pkg;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPLY,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        amount;
  } rec_t;

  typedef struct packed {
    logic push;
    logic shift;
    logic drop;
  } cell_ctrl_t;

endpackage

### rtl/fqkr_in_if.sv
// command channel of the queue
interface fqkr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] key;
  logic [31:0]        amount;

  modport source (output valid, output cmd, output key, output amount, input ready);
  modport sink (input valid, input cmd, input key, input amount, output ready);
endinterface

### rtl/fqkr_out_if.sv
// result channel of the queue
interface fqkr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_key;
  logic [31:0]        out_amount;
  logic               last;

  modport source (output valid, output status, output out_key, output out_amount,
                  output last, input ready);
  modport sink (input valid, input status, input out_key, input out_amount,
                input last, output ready);
endinterface

### rtl/fqkr_cell.sv
// one record slot of the queue chain
module fqkr_cell
  import fqkr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  cell_ctrl_t                         ctrl,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   len,
  input  rec_t                               in_rec,
  input  rec_t                               front,
  input  rec_t                               nbr,
  output rec_t                               rec
);

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  logic is_load;
  logic is_tail;

  assign is_load = (len == LW'(IDX));
  assign is_tail = (len == LW'(IDX + 1));

  // the tail slot takes the front record back in, unless it is being dropped
  always_ff @(posedge clk) begin
    if (ctrl.push && is_load) begin
      rec <= in_rec;
    end else if (ctrl.shift) begin
      rec <= (is_tail && !ctrl.drop) ? front : nbr;
    end
  end

endmodule

### rtl/fifo_queue_with_key_removal.sv
// queue top level: fill count, sequencer, cell chain and result register
// push: registered into the result register as it is accepted; remove: fill_count rotation steps
// in the scan state, then the reply state; dump: from the dump state, one record per cycle, fill_count records,
// each held while the result is not taken; the rotation sets the remove and dump times
// reset (synchronous) empties the queue and the result register; slot contents are kept
`include "fifo_queue_with_key_removal_macros.svh"
module fifo_queue_with_key_removal
  import fqkr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  fqkr_in_if.sink     req,
  fqkr_out_if.source  rsp
);

  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH = LW'(QUEUE_DEPTH);
  localparam logic [LW-1:0] ONE   = LW'(1);

  state_t             state, state_next;
  logic [LW-1:0]      fill, fill_next;
  logic [LW-1:0]      steps, steps_next;
  logic               found, found_next;
  logic signed [31:0] key_reg;
  cell_ctrl_t         ctrl;
  rec_t               in_rec;
  rec_t               cells [QUEUE_DEPTH];

  logic    out_valid;
  status_t out_status, out_status_d;
  rec_t    out_rec, out_rec_d;
  logic    out_last, out_last_d;
  logic    out_load;
  logic    out_free;
  logic    accept;

  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept = req.valid && req.ready;
  assign in_rec = '{key: req.key, amount: req.amount};

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      fqkr_cell #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .IDX(g)
      ) u_cell (
        .clk(clk),
        .ctrl(ctrl),
        .len(fill),
        .in_rec(in_rec),
        .front(cells[0]),
        .nbr(cells[(g + 1) % QUEUE_DEPTH]),
        .rec(cells[g])
      );
    end
  endgenerate

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    steps_next   = steps;
    found_next   = found;
    ctrl         = '0;
    out_load     = 1'b0;
    out_status_d = ST_OK;
    out_rec_d    = '0;
    out_last_d   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_PUSH: begin
              out_load = 1'b1;
              if (fill == DEPTH) begin
                out_status_d = ST_FULL;
              end else begin
                ctrl.push = 1'b1;
                fill_next = fill + ONE;
              end
            end
            CMD_REMOVE: begin
              if (fill == '0) begin
                out_load     = 1'b1;
                out_status_d = ST_NOT_FOUND;
              end else begin
                steps_next = fill;
                found_next = 1'b0;
                state_next = S_SCAN;
              end
            end
            CMD_DUMP: begin
              if (fill == '0) begin
                out_load     = 1'b1;
                out_status_d = ST_EMPTY;
              end else begin
                steps_next = fill;
                state_next = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // rotate every record past the front once, dropping the first match
        ctrl.shift = 1'b1;
        ctrl.drop  = !found && (cells[0].key == key_reg);
        if (ctrl.drop) begin
          fill_next = fill - ONE;
        end
        found_next = found || ctrl.drop;
        steps_next = steps - ONE;
        if (steps == ONE) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = found ? ST_OK : ST_NOT_FOUND;
          state_next   = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_rec_d  = cells[0];
          out_last_d = (steps == ONE);
          ctrl.shift = 1'b1;
          steps_next = steps - ONE;
          if (steps == ONE) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      steps     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      steps <= steps_next;
      found <= found_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg <= req.key;
    end
    if (out_load) begin
      out_status <= out_status_d;
      out_rec    <= out_rec_d;
      out_last   <= out_last_d;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.out_key    = out_rec.key;
  assign rsp.out_amount = out_rec.amount;
  assign rsp.last       = out_last;

  `FQKR_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= DEPTH)
  `FQKR_ASSERT_NEXT(a_push_grows, clk, rst,
    accept && req.cmd == CMD_PUSH && fill != DEPTH, fill == $past(fill) + ONE)
  `FQKR_ASSERT_NEXT(a_dump_keeps_fill, clk, rst, state == S_DUMP, fill == $past(fill))
  `FQKR_ASSERT_NEXT(a_scan_single_drop, clk, rst,
    state == S_SCAN && found, fill == $past(fill))

endmodule
